FILE: design/afe_pkg.sv
package afe_pkg;

   localparam logic [10:0] MAX_ELEMENTS = 11'd1024;

   localparam int unsigned MUL_W  = 33;
   localparam int unsigned PROD_W = 2 * MUL_W;

   localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
   localparam logic [32:0] HALF_PI_Q30    = 33'd1686629713;
   localparam logic [32:0] LN2_Q30        = 33'd744261118;
   localparam logic [32:0] B_OVER_LN2_Q30 = 33'd309816401;
   localparam logic [32:0] LOG2E_Q30      = 33'd1549082005;

   localparam logic [35:0] V_BIAS   = 36'd24393569369;
   localparam logic [47:0] FIT_NUM  = 48'd4294967296000;
   localparam logic [39:0] SQ_MAX   = 40'hFF_FFFF_FFFF;
   localparam logic signed [28:0] CS_MAX = 29'sd134217727;
   localparam logic signed [28:0] CS_MIN = -29'sd134217728;
   localparam logic [22:0] FV_MAX   = 23'h1F_FFFF;
   localparam logic [47:0] FIT_MAX  = 48'h3FF_FFFF;
   localparam logic [47:0] MEAN_MAX = 48'h4000_0000;
   localparam logic [47:0] MAG_MAX  = 48'h1_0000;

   localparam logic [3:0] COS_LAST  = 4'd4;
   localparam logic [3:0] EXP_LAST  = 4'd9;
   localparam logic [5:0] DIV_LAST  = 6'd47;
   localparam logic [5:0] SQRT_LAST = 6'd23;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQ, ST_HP, ST_TT, ST_T2, ST_DMUL, ST_DSH, ST_POLY, ST_COS,
      ST_MEAN, ST_DIV, ST_DIVEND, ST_SQRT, ST_W1, ST_W1S, ST_P2, ST_U, ST_US,
      ST_P2END, ST_CMAG, ST_W2S, ST_V1, ST_V2, ST_FIT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {POLY_COS, POLY_E1, POLY_E2} poly_type;

   typedef enum logic [1:0] {PASS_MEAN, PASS_CMAG, PASS_FIT} pass_type;

   typedef struct packed {
      logic [32:0] mul;
      logic [5:0]  sh;
   } magic_type;

   function automatic logic [6:0] poly_den(poly_type mode, logic [3:0] step);
      logic [6:0] k;
      if (mode == POLY_COS) begin
         case (step)
            4'd0:    k = 7'd90;
            4'd1:    k = 7'd56;
            4'd2:    k = 7'd30;
            4'd3:    k = 7'd12;
            default: k = 7'd2;
         endcase
      end else begin
         k = 7'd10 - {3'b000, step};
      end
      return k;
   endfunction

   // floor(x/k) = (x * mul) >> sh for every x below 2^32
   function automatic magic_type div_magic(logic [6:0] k);
      magic_type r;
      case (k)
         7'd1:    r = '{mul: 33'h1_0000_0000, sh: 6'd32};
         7'd2:    r = '{mul: 33'h1_0000_0000, sh: 6'd33};
         7'd3:    r = '{mul: 33'd5726623062,  sh: 6'd34};
         7'd4:    r = '{mul: 33'h1_0000_0000, sh: 6'd34};
         7'd5:    r = '{mul: 33'd6871947674,  sh: 6'd35};
         7'd6:    r = '{mul: 33'd5726623062,  sh: 6'd35};
         7'd7:    r = '{mul: 33'd4908534053,  sh: 6'd35};
         7'd8:    r = '{mul: 33'h1_0000_0000, sh: 6'd35};
         7'd9:    r = '{mul: 33'd7635497416,  sh: 6'd36};
         7'd10:   r = '{mul: 33'd6871947674,  sh: 6'd36};
         7'd12:   r = '{mul: 33'd5726623062,  sh: 6'd36};
         7'd30:   r = '{mul: 33'd4581298450,  sh: 6'd37};
         7'd56:   r = '{mul: 33'd4908534053,  sh: 6'd38};
         7'd90:   r = '{mul: 33'd6108397933,  sh: 6'd39};
         default: r = '{mul: 33'h1_0000_0000, sh: 6'd32};
      endcase
      return r;
   endfunction

endpackage

FILE: design/ackley_fitness_evaluator.sv
// Ackley fitness evaluator.
// Input channel req_*: one vector coordinate per transfer, signed Q7.16 in
// req_tdata, req_tlast marks the final coordinate of a vector. Result channel
// rsp_*: one transfer per vector, carrying fitness, function value and count.
// An ordinary coordinate occupies the block until its sums are updated: one
// shared 33x33 multiplier, registered, serves the square, the angle scaling
// and the five-term cosine series with its constant divisions.
// A last coordinate adds three 48-step restoring divisions (mean square,
// mean cosine, fitness), a 24-step square root and two 10-term exponential
// series, all on the same multiplier and one shift-subtract unit.
// req_tready is high only while the block is idle. Coordinates beyond 1024
// in one vector are ignored but a last flag on them still closes the vector.
// A finished result sits in an output register; the next vector is accepted
// while it waits, and a further result waits until rsp_tready takes the first.
// Synchronous reset clears the sums, the count and the output valid flag.
module ackley_fitness_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // coordinate [23:0]
   input  logic        req_tlast,   // last_element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // fitness [25:0], ackley_value [46:26],
                                    // element_count [57:47]
);
   import afe_pkg::*;

   state_type state_ff, state_in;
   poly_type  poly_ff, poly_in;
   pass_type  pass_ff, pass_in;

   logic [23:0] x_ff, x_in;
   logic        last_ff, last_in;
   logic [39:0] sq_sum_ff, sq_sum_in;
   logic signed [27:0] cos_sum_ff, cos_sum_in;
   logic [10:0] count_ff, count_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] b_ff, b_in;
   logic [3:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [5:0]  amt_ff, amt_in;
   logic [47:0] quo_ff, quo_in;
   logic [27:0] rem_ff, rem_in;
   logic [21:0] dvs_ff, dvs_in;
   logic [47:0] sh_ff, sh_in;
   logic [5:0]  it_ff, it_in;
   logic [35:0] w_ff, w_in;
   logic [33:0] e1_ff, e1_in;
   logic [33:0] e2_ff, e2_in;
   logic [20:0] fv_ff, fv_in;
   logic [25:0] fit_ff, fit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [MUL_W-1:0]  op_a, op_b;
   logic [PROD_W-1:0] prod_shift;
   magic_type         mg;
   logic [23:0] abs_x;
   logic [15:0] phase;
   logic [16:0] half_fold, quarter;
   logic        cos_neg;
   logic [40:0] sq_add;
   logic [35:0] q_poly;
   logic [31:0] c_round;
   logic [17:0] c_mag;
   logic signed [28:0] c_term, cs_sum;
   logic [27:0] cs_mag;
   logic [10:0] n_eff;
   logic [27:0] div_trial;
   logic [27:0] sq_trial, sq_root_trial;
   logic [30:0] mean_c;
   logic [16:0] mag_c;
   logic        p2_neg, p2_direct;
   logic [5:0]  wk;
   logic [29:0] wf;
   logic [33:0] p2_val, p2_end;
   logic [31:0] p2_g;
   logic [5:0]  p2_amt;
   logic [35:0] v_pos;
   logic [36:0] fv_round;
   logic [21:0] den;
   logic [3:0]  poly_last;
   logic        out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mg         = div_magic(poly_den(poly_ff, step_ff));
   assign prod_shift = prod_ff >> mg.sh;
   assign abs_x      = x_ff[23] ? (24'd0 - x_ff) : x_ff;
   assign phase      = x_ff[15:0];
   assign half_fold  = (phase > 16'd32768) ? (17'd65536 - {1'b0, phase}) : {1'b0, phase};
   assign cos_neg    = (half_fold > 17'd16384);
   assign quarter    = cos_neg ? (17'd32768 - half_fold) : half_fold;
   assign sq_add     = {1'b0, sq_sum_ff} + {10'd0, prod_ff[46:16]};
   assign q_poly     = prod_ff[65:30];
   assign c_round    = b_ff + 32'd8192;
   assign c_mag      = c_round[31:14];
   assign c_term     = neg_ff ? -$signed({11'd0, c_mag}) : $signed({11'd0, c_mag});
   assign cs_sum     = $signed({cos_sum_ff[27], cos_sum_ff}) + c_term;
   assign cs_mag     = cos_sum_ff[27] ? (28'd0 - $unsigned(cos_sum_ff))
                                      : $unsigned(cos_sum_ff);
   assign n_eff      = (count_ff == 11'd0) ? 11'd1 : count_ff;
   assign div_trial  = {rem_ff[26:0], quo_ff[47]};
   assign sq_trial   = {rem_ff[25:0], sh_ff[47:46]};
   assign sq_root_trial = {2'b00, quo_ff[23:0], 2'b01};
   assign mean_c     = (quo_ff > MEAN_MAX) ? MEAN_MAX[30:0] : quo_ff[30:0];
   assign mag_c      = (quo_ff > MAG_MAX) ? MAG_MAX[16:0] : quo_ff[16:0];
   assign poly_last  = (poly_ff == POLY_COS) ? COS_LAST : EXP_LAST;
   assign out_load   = !rsp_valid_ff || rsp_tready;

   // power-of-two setup
   assign wk     = w_ff[35:30];
   assign wf     = w_ff[29:0];
   assign p2_neg = (poly_ff == POLY_E1) || cos_sum_ff[27];
   always_comb begin
      p2_direct = 1'b0;
      p2_val    = '0;
      p2_g      = {2'b00, wf};
      p2_amt    = (wk > 6'd2) ? 6'd2 : wk;
      if (p2_neg) begin
         p2_g   = ONE_Q30 - {2'b00, wf};
         p2_amt = wk + 6'd1;
         if (wf == 30'd0) begin
            p2_direct = 1'b1;
            p2_val    = (wk == 6'd63) ? 34'd0 : {2'b00, ONE_Q30 >> wk};
         end else if (wk >= 6'd62) begin
            p2_direct = 1'b1;
         end
      end
   end
   assign p2_end = neg_ff ? {2'b00, b_ff >> amt_ff} : ({2'b00, b_ff} << amt_ff);

   assign v_pos    = (w_ff <= V_BIAS) ? (V_BIAS - w_ff) : 36'd0;
   assign fv_round = {1'b0, v_pos} + 37'd8192;
   assign den      = 22'h10000 + {1'b0, fv_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (count_ff < MAX_ELEMENTS) begin
                  state_in = ST_SQ;
               end else if (req_tlast) begin
                  state_in = ST_MEAN;
               end
            end
         end
         ST_SQ:   state_in = ST_HP;
         ST_HP:   state_in = ST_TT;
         ST_TT:   state_in = ST_T2;
         ST_T2:   state_in = ST_DMUL;
         ST_DMUL: state_in = ST_DSH;
         ST_DSH:  state_in = ST_POLY;
         ST_POLY: begin
            if (step_ff == poly_last) begin
               state_in = (poly_ff == POLY_COS) ? ST_COS : ST_P2END;
            end else begin
               state_in = ST_DMUL;
            end
         end
         ST_COS:  state_in = last_ff ? ST_MEAN : ST_IDLE;
         ST_MEAN: state_in = ST_DIV;
         ST_DIV: begin
            if (it_ff == DIV_LAST) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            case (pass_ff)
               PASS_MEAN: state_in = ST_SQRT;
               PASS_CMAG: state_in = ST_W2S;
               PASS_FIT:  state_in = ST_OUT;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_SQRT: begin
            if (it_ff == SQRT_LAST) begin
               state_in = ST_W1;
            end
         end
         ST_W1:  state_in = ST_W1S;
         ST_W1S: state_in = ST_P2;
         ST_P2: begin
            if (p2_direct) begin
               state_in = (poly_ff == POLY_E1) ? ST_CMAG : ST_V1;
            end else begin
               state_in = ST_U;
            end
         end
         ST_U:     state_in = ST_US;
         ST_US:    state_in = ST_DMUL;
         ST_P2END: state_in = (poly_ff == POLY_E1) ? ST_CMAG : ST_V1;
         ST_CMAG:  state_in = ST_DIV;
         ST_W2S:   state_in = ST_P2;
         ST_V1:    state_in = ST_V2;
         ST_V2:    state_in = ST_FIT;
         ST_FIT:   state_in = ST_DIV;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff;  last_in = last_ff;
      sq_sum_in = sq_sum_ff;  cos_sum_in = cos_sum_ff;  count_in = count_ff;
      num_in = num_ff;  b_in = b_ff;  step_in = step_ff;  poly_in = poly_ff;
      pass_in = pass_ff;  neg_in = neg_ff;  amt_in = amt_ff;
      quo_in = quo_ff;  rem_in = rem_ff;  dvs_in = dvs_ff;  sh_in = sh_ff;
      it_in = it_ff;  w_in = w_ff;  e1_in = e1_ff;  e2_in = e2_ff;
      fv_in = fv_ff;  fit_in = fit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in    = req_tdata;
               last_in = req_tlast;
            end
         end
         ST_SQ: begin
            op_a = {9'd0, abs_x};
            op_b = {9'd0, abs_x};
         end
         ST_HP: begin
            sq_sum_in = sq_add[40] ? SQ_MAX : sq_add[39:0];
            neg_in    = cos_neg;
            op_a      = {16'd0, quarter};
            op_b      = HALF_PI_Q30;
         end
         ST_TT: begin
            op_a = {1'b0, prod_ff[45:14]};
            op_b = {1'b0, prod_ff[45:14]};
         end
         ST_T2: begin
            num_in  = prod_ff[61:30];
            b_in    = ONE_Q30;
            step_in = 4'd0;
            poly_in = POLY_COS;
         end
         ST_DMUL: begin
            op_a = {1'b0, num_ff};
            op_b = mg.mul;
         end
         ST_DSH: begin
            op_a = {1'b0, prod_shift[31:0]};
            op_b = {1'b0, b_ff};
         end
         ST_POLY: begin
            if (poly_ff == POLY_COS) begin
               b_in = (q_poly >= {4'd0, ONE_Q30}) ? 32'd0 : (ONE_Q30 - q_poly[31:0]);
            end else begin
               b_in = ONE_Q30 + q_poly[31:0];
            end
            step_in = step_ff + 4'd1;
         end
         ST_COS: begin
            if (cs_sum > CS_MAX) begin
               cos_sum_in = CS_MAX[27:0];
            end else if (cs_sum < CS_MIN) begin
               cos_sum_in = CS_MIN[27:0];
            end else begin
               cos_sum_in = cs_sum[27:0];
            end
            count_in = count_ff + 11'd1;
         end
         ST_MEAN: begin
            quo_in  = {8'd0, sq_sum_ff};
            rem_in  = '0;
            dvs_in  = {11'd0, n_eff};
            it_in   = '0;
            pass_in = PASS_MEAN;
         end
         ST_DIV: begin
            if (div_trial >= {6'd0, dvs_ff}) begin
               rem_in = div_trial - {6'd0, dvs_ff};
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = div_trial;
               quo_in = {quo_ff[46:0], 1'b0};
            end
            it_in = it_ff + 6'd1;
         end
         ST_DIVEND: begin
            case (pass_ff)
               PASS_MEAN: begin
                  sh_in  = {1'b0, mean_c, 16'd0};
                  rem_in = '0;
                  quo_in = '0;
                  it_in  = '0;
               end
               PASS_CMAG: begin
                  op_a = {16'd0, mag_c};
                  op_b = LOG2E_Q30;
               end
               PASS_FIT: begin
                  fit_in = (quo_ff > FIT_MAX) ? FIT_MAX[25:0] : quo_ff[25:0];
               end
               default: begin
                  fit_in = fit_ff;
               end
            endcase
         end
         ST_SQRT: begin
            if (sq_trial >= sq_root_trial) begin
               rem_in = sq_trial - sq_root_trial;
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = sq_trial;
               quo_in = {quo_ff[46:0], 1'b0};
            end
            sh_in = {sh_ff[45:0], 2'b00};
            it_in = it_ff + 6'd1;
         end
         ST_W1: begin
            op_a = {9'd0, quo_ff[23:0]};
            op_b = B_OVER_LN2_Q30;
         end
         ST_W1S: begin
            w_in    = prod_ff[51:16];
            poly_in = POLY_E1;
         end
         ST_P2: begin
            if (p2_direct) begin
               if (poly_ff == POLY_E1) begin
                  e1_in = p2_val;
               end else begin
                  e2_in = p2_val;
               end
            end else begin
               num_in = p2_g;
               amt_in = p2_amt;
               neg_in = p2_neg;
            end
         end
         ST_U: begin
            op_a = {1'b0, num_ff};
            op_b = LN2_Q30;
         end
         ST_US: begin
            num_in  = prod_ff[61:30];
            b_in    = ONE_Q30;
            step_in = 4'd0;
         end
         ST_P2END: begin
            if (poly_ff == POLY_E1) begin
               e1_in = p2_end;
            end else begin
               e2_in = p2_end;
            end
         end
         ST_CMAG: begin
            quo_in  = {20'd0, cs_mag};
            rem_in  = '0;
            dvs_in  = {11'd0, n_eff};
            it_in   = '0;
            pass_in = PASS_CMAG;
         end
         ST_W2S: begin
            w_in    = prod_ff[51:16];
            poly_in = POLY_E2;
         end
         ST_V1: begin
            w_in = ({2'b00, e1_ff} << 4) + ({2'b00, e1_ff} << 2) + {2'b00, e2_ff};
         end
         ST_V2: begin
            fv_in = (fv_round[36:14] > FV_MAX) ? FV_MAX[20:0] : fv_round[34:14];
         end
         ST_FIT: begin
            quo_in  = FIT_NUM + {27'd0, den[21:1]};
            rem_in  = '0;
            dvs_in  = den;
            it_in   = '0;
            pass_in = PASS_FIT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, count_ff, fv_ff, fit_ff};
               sq_sum_in    = '0;
               cos_sum_in   = '0;
               count_in     = '0;
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sq_sum_ff    <= '0;
         cos_sum_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sq_sum_ff    <= sq_sum_in;
         cos_sum_ff   <= cos_sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      b_ff        <= b_in;
      step_ff     <= step_in;
      poly_ff     <= poly_in;
      pass_ff     <= pass_in;
      neg_ff      <= neg_in;
      amt_ff      <= amt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      sh_ff       <= sh_in;
      it_ff       <= it_in;
      w_ff        <= w_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      fv_ff       <= fv_in;
      fit_ff      <= fit_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_ELEMENTS)
      else $error("element count above limit");

   a_accumulate_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (count_ff < MAX_ELEMENTS)) |=> (state_ff == ST_SQ))
      else $error("accepted coordinate not accumulated");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ((dvs_ff != 22'd0) && (rem_ff < {6'd0, dvs_ff})))
      else $error("divider remainder out of range");

   a_clear_on_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_load) |=>
         (rsp_tvalid && count_ff == 11'd0 && sq_sum_ff == 40'd0 && cos_sum_ff == 28'sd0))
      else $error("accumulators not cleared with result");

endmodule
